// ----- rtl/core/gcar_pkg.sv -----
package gcar_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CODE_W          = 21;
  localparam int PRIO_W          = 16;
  localparam int CFG_W           = 5;
  localparam int SLOT_W          = 4;
  localparam int STATUS_W        = 2;
  localparam int ENTRIES_RESET   = 16;

  localparam logic [PRIO_W-1:0] PRIO_TOP = 16'hffff;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 2'd0,
    ST_FILLED = 2'd1,
    ST_FAILED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_AGE,
    S_RESP,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              glyph_available;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } out_t;

endpackage

// ----- rtl/core/gcar_ram.sv -----
module gcar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/glyph_cache_aging_replacement.sv -----
// One request is in flight at a time: a new beat is taken only once the previous
// result has been loaded into the output register and the block is back in idle.
// Each request sweeps the slots in use through the single read port of the tag and
// priority stores for the tag/minimum search; a hit or a fill then makes a
// read-modify-write sweep to age the priorities, which a failed request skips.
// Reset (rst_n, synchronous): a clearing pass zeroes tags and priorities slot by slot
// with in_ready low, slots in use returns to 16, no result pending.
module glyph_cache_aging_replacement #(
  parameter int MAX_ENTRIES = gcar_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gcar_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gcar_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [gcar_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  gcar_pkg::state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              pend_r, pend_nxt;
  logic [IDX_W-1:0]                  pend_idx_r, pend_idx_nxt;
  logic [gcar_pkg::CODE_W-1:0]       code_r, code_nxt;
  logic                              avail_r, avail_nxt;
  logic                              hit_r, hit_nxt;
  logic [IDX_W-1:0]                  match_idx_r, match_idx_nxt;
  logic [gcar_pkg::PRIO_W-1:0]       min_r, min_nxt;
  logic [IDX_W-1:0]                  min_idx_r, min_idx_nxt;
  logic [IDX_W-1:0]                  chosen_r, chosen_nxt;
  gcar_pkg::status_t                 status_r, status_nxt;
  logic                              out_valid_r, out_valid_nxt;
  gcar_pkg::out_t                    out_data_r, out_data_nxt;
  logic [gcar_pkg::CFG_W-1:0]        ent_r, ent_nxt;

  logic [CNT_W-1:0]                  n_w;
  logic [IDX_W-1:0]                  rd_addr;
  logic                              issue;
  logic                              tag_we;
  logic [IDX_W-1:0]                  tag_waddr;
  logic [gcar_pkg::CODE_W-1:0]       tag_wdata;
  logic                              pri_we;
  logic [IDX_W-1:0]                  pri_waddr;
  logic [gcar_pkg::PRIO_W-1:0]       pri_wdata;
  logic [gcar_pkg::CODE_W-1:0]       tag_rdata;
  logic [gcar_pkg::PRIO_W-1:0]       pri_rdata;

  gcar_ram #(
    .WIDTH (gcar_pkg::CODE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (rd_addr),
    .rdata (tag_rdata)
  );

  gcar_ram #(
    .WIDTH (gcar_pkg::PRIO_W),
    .DEPTH (MAX_ENTRIES)
  ) u_pri_ram (
    .clk   (clk),
    .we    (pri_we),
    .waddr (pri_waddr),
    .wdata (pri_wdata),
    .raddr (rd_addr),
    .rdata (pri_rdata)
  );

  // Clamp slots in use to 1..MAX_ENTRIES.
  always_comb begin
    if (ent_r == '0) begin
      n_w = CNT_W'(1);
    end else if (int'(ent_r) > MAX_ENTRIES) begin
      n_w = CNT_W'(MAX_ENTRIES);
    end else begin
      n_w = CNT_W'(ent_r);
    end
  end

  assign rd_addr = cnt_r[IDX_W-1:0];
  assign issue   = ((state_r == gcar_pkg::S_SCAN) || (state_r == gcar_pkg::S_AGE)) &&
                   (cnt_r < n_w);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    code_nxt      = code_r;
    avail_nxt     = avail_r;
    hit_nxt       = hit_r;
    match_idx_nxt = match_idx_r;
    min_nxt       = min_r;
    min_idx_nxt   = min_idx_r;
    chosen_nxt    = chosen_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ent_nxt       = ent_r;
    tag_we        = 1'b0;
    tag_waddr     = min_idx_r;
    tag_wdata     = code_r;
    pri_we        = 1'b0;
    pri_waddr     = pend_idx_r;
    pri_wdata     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      ent_nxt = cfg_wdata;
    end

    case (state_r)
      gcar_pkg::S_CLEAR: begin
        // Zero one slot of each store per cycle after reset.
        tag_we    = 1'b1;
        tag_waddr = cnt_r[IDX_W-1:0];
        tag_wdata = '0;
        pri_we    = 1'b1;
        pri_waddr = cnt_r[IDX_W-1:0];
        pri_wdata = '0;
        if (cnt_r == CNT_W'(MAX_ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = gcar_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      gcar_pkg::S_IDLE: begin
        if (in_valid) begin
          code_nxt      = in_data.char_code;
          avail_nxt     = in_data.glyph_available;
          cnt_nxt       = '0;
          pend_nxt      = 1'b0;
          hit_nxt       = 1'b0;
          match_idx_nxt = '0;
          min_nxt       = gcar_pkg::PRIO_TOP;
          min_idx_nxt   = '0;
          state_nxt     = gcar_pkg::S_SCAN;
        end
      end
      gcar_pkg::S_SCAN: begin
        pend_nxt     = issue;
        pend_idx_nxt = rd_addr;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // Later slots win on both the tag match and the minimum tie.
        if (pend_r) begin
          if (tag_rdata == code_r) begin
            hit_nxt       = 1'b1;
            match_idx_nxt = pend_idx_r;
          end
          if (pri_rdata <= min_r) begin
            min_nxt     = pri_rdata;
            min_idx_nxt = pend_idx_r;
          end
        end
        if (!issue && !pend_r) begin
          state_nxt = gcar_pkg::S_DECIDE;
        end
      end
      gcar_pkg::S_DECIDE: begin
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
        if (hit_r) begin
          chosen_nxt = match_idx_r;
          status_nxt = gcar_pkg::ST_HIT;
          state_nxt  = gcar_pkg::S_AGE;
        end else if (!avail_r) begin
          chosen_nxt = '0;
          status_nxt = gcar_pkg::ST_FAILED;
          state_nxt  = gcar_pkg::S_RESP;
        end else begin
          tag_we     = 1'b1;
          chosen_nxt = min_idx_r;
          status_nxt = gcar_pkg::ST_FILLED;
          state_nxt  = gcar_pkg::S_AGE;
        end
      end
      gcar_pkg::S_AGE: begin
        pend_nxt     = issue;
        pend_idx_nxt = rd_addr;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // Write back slot read last cycle while the next one is read.
        if (pend_r) begin
          pri_we    = 1'b1;
          pri_wdata = (pend_idx_r == chosen_r) ? gcar_pkg::PRIO_TOP : (pri_rdata - 1'b1);
        end
        if (!issue && !pend_r) begin
          state_nxt = gcar_pkg::S_RESP;
        end
      end
      gcar_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = status_r;
          out_data_nxt.slot   = gcar_pkg::SLOT_W'(chosen_r);
          state_nxt           = gcar_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gcar_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcar_pkg::S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ent_r       <= gcar_pkg::CFG_W'(gcar_pkg::ENTRIES_RESET);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      ent_r       <= ent_nxt;
    end
    pend_idx_r  <= pend_idx_nxt;
    code_r      <= code_nxt;
    avail_r     <= avail_nxt;
    match_idx_r <= match_idx_nxt;
    min_r       <= min_nxt;
    min_idx_r   <= min_idx_nxt;
    chosen_r    <= chosen_nxt;
    status_r    <= status_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = (state_r == gcar_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status != gcar_pkg::ST_FAILED || out_data_r.slot == '0))
    else $error("failed result carries a nonzero slot");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == gcar_pkg::S_SCAN))
    else $error("accepted beat did not start the tag scan");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcar_pkg::S_SCAN) |-> (!tag_we && !pri_we))
    else $error("store written during the search sweep");

  a_tag_fill: assert property (@(posedge clk) disable iff (!rst_n)
    tag_we |-> ((state_r == gcar_pkg::S_CLEAR) ||
                (state_r == gcar_pkg::S_DECIDE && !hit_r && avail_r)))
    else $error("tag written outside a filled miss");

endmodule
